// File: rtl/core/prim_asm_pkg.sv
package prim_asm_pkg;

  // Width of a vertex reference on the ports.
  localparam int unsigned VertexFieldBits = 16;
  // Bits of a vertex reference that the queue keeps.
  localparam int unsigned VertexRefBits   = 16;
  localparam int unsigned RefW =
      (VertexRefBits < VertexFieldBits) ? VertexRefBits : VertexFieldBits;

  typedef logic [VertexFieldBits-1:0] vertex_t;
  typedef logic [RefW-1:0]            ref_t;

  // Draw modes; codes 10..15 are undefined and never emit.
  localparam logic [3:0] ModePoints    = 4'd0;
  localparam logic [3:0] ModeLines     = 4'd1;
  localparam logic [3:0] ModeLineLoop  = 4'd2;
  localparam logic [3:0] ModeLineStrip = 4'd3;
  localparam logic [3:0] ModeTriangles = 4'd4;
  localparam logic [3:0] ModeTriStrip  = 4'd5;
  localparam logic [3:0] ModeTriFan    = 4'd6;
  localparam logic [3:0] ModeQuads     = 4'd7;
  localparam logic [3:0] ModeQuadStrip = 4'd8;
  localparam logic [3:0] ModePolygon   = 4'd9;

  // Configuration register indexes.
  localparam logic CfgDrawMode  = 1'b0;
  localparam logic CfgPrimCount = 1'b1;

  localparam logic OpPush    = 1'b0;
  localparam logic OpRestart = 1'b1;

  localparam logic [1:0] TotalPoint    = 2'd1;
  localparam logic [1:0] TotalLine     = 2'd2;
  localparam logic [1:0] TotalTriangle = 2'd3;

  typedef struct packed {
    logic    operation;
    vertex_t vertex_ref;
  } in_item_t;

  typedef struct packed {
    vertex_t    vertex_a;
    vertex_t    vertex_b;
    vertex_t    vertex_c;
    logic [1:0] vertex_total;
  } out_item_t;

  // Classified word handed from the front to the back.
  typedef struct packed {
    logic restart;
    ref_t vref;
  } cmd_t;

endpackage

// File: rtl/core/prim_asm_front.sv
module prim_asm_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  prim_asm_pkg::in_item_t in_item_i,
  output logic                   cmd_valid_o,
  input  logic                   cmd_ready_i,
  output prim_asm_pkg::cmd_t     cmd_o
);
  import prim_asm_pkg::*;

  cmd_t       fifo_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push, pop;
  cmd_t       cmd_new;

  // Classify: a restart word carries no vertex.
  always_comb begin
    cmd_new.restart = (in_item_i.operation == OpRestart);
    cmd_new.vref    = in_item_i.vertex_ref[RefW-1:0];
  end

  assign in_ready_o  = (count_q != 2'd2);
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = fifo_q[rd_ptr_q];

  assign push = in_valid_i && in_ready_o;
  assign pop  = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

// File: rtl/core/prim_asm_back.sv
module prim_asm_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic                    cfg_index_i,
  input  logic [15:0]             cfg_data_i,
  input  logic                    cmd_valid_i,
  output logic                    cmd_ready_o,
  input  prim_asm_pkg::cmd_t      cmd_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output prim_asm_pkg::out_item_t out_item_o
);
  import prim_asm_pkg::*;

  logic [3:0]  mode_q;
  logic [15:0] prim_count_q;
  ref_t        queue_q [3];
  ref_t        queue_d [3];
  ref_t        q_ins   [3];
  logic [1:0]  fill_q, fill_d, fill_ins;
  logic [15:0] cnt_q, cnt_d;
  ref_t        saved_q, saved_d;
  logic        out_valid_q;
  out_item_t   out_q;

  logic        fire, emit, odd, first, last, counts;
  logic [1:0]  pop;
  ref_t        va, vb, vc;
  logic        zero_b, zero_c;
  logic [1:0]  total;
  logic [2:0]  src;

  assign cmd_ready_o = !out_valid_q || out_ready_i;
  assign fire        = cmd_valid_i && cmd_ready_o;

  always_comb begin
    // Append the vertex unless the word is a restart or the queue is full.
    for (int i = 0; i < 3; i++) begin
      q_ins[i] = queue_q[i];
    end
    fill_ins = fill_q;
    if (!cmd_i.restart && fill_q != 2'd3) begin
      q_ins[fill_q] = cmd_i.vref;
      fill_ins      = fill_q + 2'd1;
    end

    odd     = cnt_q[0];
    first   = (cnt_q == 16'd0);
    last    = (prim_count_q != 16'd0) && (cnt_q == prim_count_q - 16'd1);
    emit    = 1'b0;
    counts  = 1'b1;
    pop     = 2'd0;
    saved_d = saved_q;
    va      = q_ins[0];
    vb      = q_ins[1];
    vc      = q_ins[2];
    zero_b  = 1'b0;
    zero_c  = 1'b0;
    total   = TotalTriangle;

    unique case (mode_q) inside
      ModePoints: begin
        emit   = (fill_ins != 2'd0);
        counts = 1'b0;
        zero_b = 1'b1;
        zero_c = 1'b1;
        total  = TotalPoint;
        pop    = 2'd1;
      end
      ModeLines, ModeLineLoop, ModeLineStrip: begin
        emit   = (fill_ins >= 2'd2);
        zero_c = 1'b1;
        total  = TotalLine;
        pop    = (mode_q == ModeLines) ? 2'd2 : 2'd1;
        if (mode_q == ModeLineLoop) begin
          if (first) begin
            saved_d = q_ins[0];
          end
          if (last) begin
            vb = saved_d;
          end
        end
      end
      ModeTriangles: begin
        emit = (fill_ins == 2'd3);
        pop  = 2'd3;
      end
      ModeTriStrip: begin
        emit = (fill_ins == 2'd3);
        pop  = 2'd1;
        if (odd) begin
          va = q_ins[1];
          vb = q_ins[0];
        end
      end
      ModeTriFan, ModePolygon: begin
        emit = (fill_ins == 2'd3);
        pop  = 2'd1;
        if (first) begin
          saved_d = q_ins[0];
        end
        va = saved_d;
      end
      ModeQuads: begin
        emit = (fill_ins == 2'd3);
        if (odd) begin
          va  = saved_q;
          pop = 2'd3;
        end else begin
          saved_d = q_ins[0];
          pop     = 2'd1;
        end
      end
      ModeQuadStrip: begin
        emit = (fill_ins == 2'd3);
        pop  = 2'd1;
        if (odd) begin
          vb = q_ins[2];
          vc = q_ins[1];
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase

    if (cmd_i.restart) begin
      emit = 1'b0;
    end
    if (!emit) begin
      pop     = 2'd0;
      saved_d = saved_q;
    end

    // Pop from the front.
    for (int i = 0; i < 3; i++) begin
      src = 3'(i) + {1'b0, pop};
      queue_d[i] = (src < 3'd3) ? q_ins[src[1:0]] : q_ins[i];
    end

    if (cmd_i.restart) begin
      fill_d = 2'd0;
      cnt_d  = 16'd0;
    end else begin
      fill_d = fill_ins - pop;
      cnt_d  = (emit && counts) ? cnt_q + 16'd1 : cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= ModeTriangles;
      prim_count_q <= 16'd0;
      fill_q       <= 2'd0;
      cnt_q        <= 16'd0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_index_i == CfgDrawMode) begin
        mode_q <= cfg_data_i[3:0];
      end
      if (cfg_we_i && cfg_index_i == CfgPrimCount) begin
        prim_count_q <= cfg_data_i;
      end
      if (fire) begin
        fill_q <= fill_d;
        cnt_q  <= cnt_d;
      end
      if (fire && emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      for (int i = 0; i < 3; i++) begin
        queue_q[i] <= queue_d[i];
      end
      saved_q <= saved_d;
    end
    if (fire && emit) begin
      out_q.vertex_a     <= vertex_t'(va);
      out_q.vertex_b     <= zero_b ? '0 : vertex_t'(vb);
      out_q.vertex_c     <= zero_c ? '0 : vertex_t'(vc);
      out_q.vertex_total <= total;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// File: rtl/core/primitive_assembler_core.sv
// Channel | Direction | Handshake             | Word
// --------+-----------+-----------------------+-------------------------------------
// in      | input     | in_valid_i/in_ready_o | in_item_t: operation, vertex_ref
// out     | output    | out_valid_o/out_ready_i | out_item_t: vertex_a/b/c, vertex_total
// cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One word per cycle sustained while the output is not stalled: the back assembler
// consumes one queued word per cycle and produces at most one primitive into its
// output register. From input accept to result valid a word passes the front queue,
// then the output register; the two-entry front queue buffers words under stalls.
// Reset clears draw mode to triangles, count to zero, and empties both stages.
// Config writes are taken only while the front queue is empty.
module primitive_assembler_core (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  prim_asm_pkg::in_item_t  in_item_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output prim_asm_pkg::out_item_t out_item_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic                    cfg_index_i,
  input  logic [15:0]             cfg_data_i
);
  import prim_asm_pkg::*;

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  // Front: accept and classify words, hold them in a short queue.
  prim_asm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  // Hold off config while words are still queued for the back.
  assign cfg_ready_o = !cmd_valid;

  // Back: vertex queue, counters, primitive assembly, output register.
  prim_asm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

// File: rtl/core/prim_asm_checker.sv
module prim_asm_checker (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    out_valid_o,
  input logic                    out_ready_i,
  input prim_asm_pkg::out_item_t out_item_o
);
  import prim_asm_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped under stall");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_item_o))
    else $error("result changed under stall");

  a_total_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.vertex_total != 2'd0)
    else $error("empty primitive");

  a_unused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.vertex_total != TotalTriangle
      |-> out_item_o.vertex_c == '0 &&
          (out_item_o.vertex_total != TotalPoint || out_item_o.vertex_b == '0))
    else $error("unused vertex slot not cleared");

endmodule

bind primitive_assembler_core prim_asm_checker u_prim_asm_checker (.*);
